[hw/rtl/clap_pkg.sv]
// ----------------------------------------------------------------------------
// clap_pkg: shared definitions for the common-links-across-paths block
// Sizes, operation codes and controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package clap_pkg;

  localparam int NUM_LINKS = 1024;
  localparam int MAX_PATHS = 255;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 10;
  localparam int LINK_AW = $clog2(NUM_LINKS);
  localparam int LEN_W   = $clog2(NUM_LINKS + 1);
  localparam int CNT_W   = $clog2(MAX_PATHS + 1);

  localparam logic [OP_W-1:0] OP_LINK  = 2'd0;
  localparam logic [OP_W-1:0] OP_END   = 2'd1;
  localparam logic [OP_W-1:0] OP_DRAIN = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LINK_RD,
    ST_DRAIN_LIST,
    ST_DRAIN_CNT
  } st_t;

endpackage

`default_nettype wire

[hw/rtl/common_links_across_paths.sv]
// ----------------------------------------------------------------------------
// common_links_across_paths: links shared by every path of a set
// Counts link occurrences per link in a memory, records first-seen links in
// a list memory, and drains that list one entry per drain item.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake       Payload
//  -------   -------------   ----------------------------------------------
//  input     start / busy    in_operation, in_link_index
//  result    out_valid       out_link_index_res, out_common, out_last,
//                            out_empty_res
//
// An item is taken at a clock edge with start high and busy low. A link item
// occupies the block through a count read and then a write back, an
// end-of-path item leaves busy low, and a drain item runs through a list
// read, a count read and a count clear, or leaves busy low when the list is
// empty. These steps come from the registered reads of the count and list
// memories, chained for a drain. After reset the count memory is swept to
// zero, one entry a cycle, over all NUM_LINKS (1024) entries while busy is
// high. A result is shown for one cycle under out_valid; the receiver cannot
// stall it, and the block may already take the next item in that cycle.
`default_nettype none

module common_links_across_paths (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [clap_pkg::OP_W-1:0]  in_operation,
  input  logic [clap_pkg::IDX_W-1:0] in_link_index,
  output logic                       out_valid,
  output logic [clap_pkg::IDX_W-1:0] out_link_index_res,
  output logic                       out_common,
  output logic                       out_last,
  output logic                       out_empty_res
);

  import clap_pkg::*;

  // Controller state and set bookkeeping.
  st_t               state_r, state_nxt;
  logic [LINK_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [LINK_AW-1:0] link_r, link_nxt;
  logic [LEN_W-1:0]   list_len_r, list_len_nxt;
  logic [LEN_W-1:0]   drain_pos_r, drain_pos_nxt;
  logic [CNT_W-1:0]   path_cnt_r, path_cnt_nxt;

  // Result registers.
  logic               out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]   out_link_r, out_link_nxt;
  logic               out_common_r, out_common_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_empty_r, out_empty_nxt;

  // Memory ports.
  logic               cnt_we, cnt_re;
  logic [LINK_AW-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
  logic               list_we, list_re;
  logic [LINK_AW-1:0] list_waddr, list_raddr;
  logic [LINK_AW-1:0] list_wdata, list_rdata;

  logic               accept;
  logic               idx_ok;
  logic               list_empty;
  logic [LEN_W-1:0]   drain_pos_inc;

  assign accept        = start && (state_r == ST_IDLE);
  assign idx_ok        = (32'(in_link_index) < NUM_LINKS);
  assign list_empty    = (drain_pos_r >= list_len_r);
  assign drain_pos_inc = drain_pos_r + LEN_W'(1);

  // Per-link occurrence counters.
  clap_ram #(
    .DEPTH (NUM_LINKS),
    .WIDTH (CNT_W)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // First-seen list: links in the order they first appeared in the set.
  clap_ram #(
    .DEPTH (NUM_LINKS),
    .WIDTH (LINK_AW)
  ) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .re    (list_re),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == LINK_AW'(NUM_LINKS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          if (in_operation == OP_LINK && idx_ok) begin
            state_nxt = ST_LINK_RD;
          end else if (in_operation == OP_DRAIN && !list_empty) begin
            state_nxt = ST_DRAIN_LIST;
          end
        end
      end
      ST_LINK_RD:    state_nxt = ST_IDLE;
      ST_DRAIN_LIST: state_nxt = ST_DRAIN_CNT;
      ST_DRAIN_CNT:  state_nxt = ST_IDLE;
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // Memory controls and datapath updates.
  always_comb begin
    clr_addr_nxt   = clr_addr_r;
    link_nxt       = link_r;
    list_len_nxt   = list_len_r;
    drain_pos_nxt  = drain_pos_r;
    path_cnt_nxt   = path_cnt_r;
    out_valid_nxt  = 1'b0;
    out_link_nxt   = out_link_r;
    out_common_nxt = out_common_r;
    out_last_nxt   = out_last_r;
    out_empty_nxt  = out_empty_r;
    cnt_we         = 1'b0;
    cnt_waddr      = link_r;
    cnt_wdata      = '0;
    cnt_re         = 1'b0;
    cnt_raddr      = LINK_AW'(in_link_index);
    list_we        = 1'b0;
    list_waddr     = list_len_r[LINK_AW-1:0];
    list_wdata     = link_r;
    list_re        = 1'b0;
    list_raddr     = drain_pos_r[LINK_AW-1:0];

    unique case (state_r)
      ST_CLEAR: begin
        cnt_we       = 1'b1;
        cnt_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + LINK_AW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_LINK: begin
              cnt_re   = idx_ok;
              link_nxt = LINK_AW'(in_link_index);
            end
            OP_END: begin
              if (path_cnt_r < CNT_W'(MAX_PATHS)) begin
                path_cnt_nxt = path_cnt_r + CNT_W'(1);
              end
            end
            OP_DRAIN: begin
              if (list_empty) begin
                // Nothing left: report an empty drain and close the set.
                out_valid_nxt  = 1'b1;
                out_link_nxt   = '0;
                out_common_nxt = 1'b0;
                out_last_nxt   = 1'b1;
                out_empty_nxt  = 1'b1;
                list_len_nxt   = '0;
                drain_pos_nxt  = '0;
                path_cnt_nxt   = '0;
              end else begin
                list_re = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LINK_RD: begin
        if (cnt_rdata == '0) begin
          // First sighting in this set; a full list drops the link entirely.
          if (32'(list_len_r) < NUM_LINKS) begin
            list_we      = 1'b1;
            list_len_nxt = list_len_r + LEN_W'(1);
            cnt_we       = 1'b1;
            cnt_wdata    = CNT_W'(1);
          end
        end else if (cnt_rdata < CNT_W'(MAX_PATHS)) begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt_rdata + CNT_W'(1);
        end
      end
      ST_DRAIN_LIST: begin
        cnt_re    = 1'b1;
        cnt_raddr = list_rdata;
        link_nxt  = list_rdata;
      end
      ST_DRAIN_CNT: begin
        // Clear the drained counter so the store is clean for the next set.
        cnt_we         = 1'b1;
        cnt_wdata      = '0;
        drain_pos_nxt  = drain_pos_inc;
        out_valid_nxt  = 1'b1;
        out_link_nxt   = IDX_W'(link_r);
        out_common_nxt = (cnt_rdata == path_cnt_r);
        out_last_nxt   = (drain_pos_inc >= list_len_r);
        out_empty_nxt  = 1'b0;
        if (drain_pos_inc >= list_len_r) begin
          list_len_nxt  = '0;
          drain_pos_nxt = '0;
          path_cnt_nxt  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      list_len_r  <= '0;
      drain_pos_r <= '0;
      path_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      list_len_r  <= list_len_nxt;
      drain_pos_r <= drain_pos_nxt;
      path_cnt_r  <= path_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    link_r       <= link_nxt;
    out_link_r   <= out_link_nxt;
    out_common_r <= out_common_nxt;
    out_last_r   <= out_last_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_link_index_res = out_link_r;
  assign out_common         = out_common_r;
  assign out_last           = out_last_r;
  assign out_empty_res      = out_empty_r;

  // The drain pointer never passes the end of the list.
  a_drain_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    drain_pos_r <= list_len_r)
    else $error("drain position beyond list length");

  // The list never grows past the number of links.
  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(list_len_r) <= NUM_LINKS)
    else $error("list length beyond link count");

  // A result only follows a drain: a count read, or an empty drain accepted.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == ST_DRAIN_CNT) ||
                    ($past(state_r) == ST_IDLE && $past(start) &&
                     $past(in_operation) == OP_DRAIN))
    else $error("result without a drain item");

  // An empty drain always closes the set.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_empty_r |-> out_last_r && list_len_r == '0)
    else $error("empty drain did not close the set");

  // A drain walks list read, count read, then returns to idle.
  a_drain_seq: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DRAIN_LIST |=> state_r == ST_DRAIN_CNT ##1 state_r == ST_IDLE)
    else $error("drain sequence broken");

endmodule

`default_nettype wire

[hw/rtl/clap_ram.sv]
// ----------------------------------------------------------------------------
// clap_ram: simple dual-port synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module clap_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
